/* hw/rtl/bbmp_pkg.sv */
// Shared types, codes and defaults for the bad-block merge planner.
// No dependencies; every other file but bbmp_ram imports this package.
package bbmp_pkg;

    localparam int DEF_MAX_IMAGES     = 8;
    localparam int DEF_MAX_BAD_BLOCKS = 256;
    localparam int POS_W              = 48;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SIZE   = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ACT_COPY  = 2'd0;
    localparam logic [1:0] ACT_VOTE  = 2'd1;
    localparam logic [1:0] ACT_ERROR = 2'd2;
    localparam logic [1:0] ACT_OK    = 2'd3;

    localparam logic CFG_IMAGE_COUNT   = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CSCAN,
        ST_CEVAL,
        ST_VSCAN,
        ST_VEVAL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_ERR,
        RES_COPY_LIM,
        RES_COPY_GAP,
        RES_VOTE
    } res_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     clear_lists;
        logic     append;
        logic     set_size;
        logic     scan_reset;
        logic     next_entry;
        logic     next_image;
        logic     mark_ge;
        logic     rd_en;
        logic     vote_update;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       img_ok;
        logic       list_full;
        logic       i_end;
        logic       j_end;
        logic       covers;
        logic       after;
        logic       at_pos;
        logic       better;
        logic       out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/bbmp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbmp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

/* hw/rtl/bbmp_ctrl.sv */
// Sequencer for the planner: command decode and the two query scans.
// Depends on bbmp_pkg.
module bbmp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bbmp_pkg::dp_stat_t  stat,
    output bbmp_pkg::ctrl_cmd_t cmd
);
    import bbmp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.command == CMD_QUERY)
                begin
                    state_next = ST_CSCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CSCAN:
            begin
                priority if (stat.i_end)
                begin
                    state_next = ST_VSCAN;
                end
                else if (stat.j_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CEVAL;
                end
            end
            ST_CEVAL:
            begin
                if (!stat.covers && stat.after)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CSCAN;
                end
            end
            ST_VSCAN:
            begin
                priority if (stat.i_end)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.j_end)
                begin
                    state_next = ST_VSCAN;
                end
                else
                begin
                    state_next = ST_VEVAL;
                end
            end
            ST_VEVAL:
            begin
                state_next = ST_VSCAN;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.res_sel = RES_OK;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_EXEC:
            begin
                unique case (stat.command)
                    CMD_CLEAR:
                    begin
                        cmd.clear_lists = 1'b1;
                        cmd.res_load    = 1'b1;
                        cmd.res_sel     = RES_OK;
                    end
                    CMD_APPEND:
                    begin
                        cmd.res_load = 1'b1;
                        if (stat.img_ok && !stat.list_full)
                        begin
                            cmd.append  = 1'b1;
                            cmd.res_sel = RES_OK;
                        end
                        else
                        begin
                            cmd.res_sel = RES_ERR;
                        end
                    end
                    CMD_SIZE:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.set_size = stat.img_ok;
                        cmd.res_sel  = stat.img_ok ? RES_OK : RES_ERR;
                    end
                    CMD_QUERY:
                    begin
                        cmd.scan_reset = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_sel = RES_ERR;
                    end
                endcase
            end
            ST_CSCAN:
            begin
                priority if (stat.i_end)
                begin
                    cmd.scan_reset = 1'b1;
                end
                else if (stat.j_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_COPY_LIM;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_CEVAL:
            begin
                priority if (stat.covers)
                begin
                    cmd.next_image = 1'b1;
                end
                else if (stat.after)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_COPY_GAP;
                end
                else
                begin
                    cmd.mark_ge    = stat.at_pos;
                    cmd.next_entry = 1'b1;
                end
            end
            ST_VSCAN:
            begin
                priority if (stat.i_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_VOTE;
                end
                else if (stat.j_end)
                begin
                    cmd.next_image = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_VEVAL:
            begin
                if (stat.covers && stat.better)
                begin
                    cmd.vote_update = 1'b1;
                    cmd.next_image  = 1'b1;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule

/* hw/rtl/bbmp_dp.sv */
// Datapath: config registers, list fills, image sizes, interval RAM,
// scan counters, vote tracking and the output register.
// Depends on bbmp_pkg and bbmp_ram.
module bbmp_dp #(
    parameter int MAX_IMAGES     = bbmp_pkg::DEF_MAX_IMAGES,
    parameter int MAX_BAD_BLOCKS = bbmp_pkg::DEF_MAX_BAD_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic [1:0]          command,
    input  logic [2:0]          image,
    input  logic [47:0]         offset,
    input  logic [47:0]         amount,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [1:0]          action,
    output logic [2:0]          source_image,
    output logic [47:0]         byte_count,
    input  bbmp_pkg::ctrl_cmd_t cmd,
    output bbmp_pkg::dp_stat_t  stat
);
    import bbmp_pkg::*;

    localparam int IW    = $clog2(MAX_IMAGES);
    localparam int IW1   = $clog2(MAX_IMAGES + 1);
    localparam int JW    = (MAX_BAD_BLOCKS > 1) ? $clog2(MAX_BAD_BLOCKS) : 1;
    localparam int FW    = $clog2(MAX_BAD_BLOCKS + 1);
    localparam int DEPTH = MAX_IMAGES * MAX_BAD_BLOCKS;
    localparam int AW    = $clog2(DEPTH);

    logic [3:0]        image_count_reg;
    logic [POS_W-1:0]  output_length_reg;
    logic [1:0]        cmd_reg;
    logic [2:0]        img_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  amt_reg;
    logic [FW-1:0]     fill_reg [MAX_IMAGES];
    logic [POS_W-1:0]  size_reg [MAX_IMAGES];
    logic [IW1-1:0]    i_reg;
    logic [FW-1:0]     j_reg;
    logic              ge_reg;
    logic              found_reg;
    logic [POS_W-1:0]  best_reg;
    logic [IW1-1:0]    best_img_reg;
    logic [1:0]        res_act_reg;
    logic [2:0]        res_img_reg;
    logic [POS_W-1:0]  res_cnt_reg;
    logic              out_valid_reg;
    logic [1:0]        action_reg;
    logic [2:0]        source_image_reg;
    logic [POS_W-1:0]  byte_count_reg;

    logic [IW-1:0]        img_idx;
    logic [IW-1:0]        i_idx;
    logic [IW1-1:0]       n_eff;
    logic                 img_ok;
    logic [FW-1:0]        cur_fill;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [2*POS_W-1:0]   rdata;
    logic [POS_W-1:0]     rd_start;
    logic [POS_W-1:0]     rd_len;
    logic [POS_W:0]       rd_end;
    logic [POS_W-1:0]     left;
    logic [POS_W-1:0]     lim;
    logic [POS_W-1:0]     lim_cnt;
    logic [POS_W-1:0]     cur_size;

    assign img_idx  = IW'(img_reg);
    assign i_idx    = i_reg[IW-1:0];
    assign img_ok   = 32'(img_reg) < MAX_IMAGES;
    assign n_eff    = (32'(image_count_reg) > MAX_IMAGES) ? IW1'(MAX_IMAGES)
                                                          : IW1'(image_count_reg);
    assign cur_fill = fill_reg[i_idx];
    assign cur_size = size_reg[i_idx];
    assign waddr    = AW'(32'(img_idx) * MAX_BAD_BLOCKS + 32'(fill_reg[img_idx]));
    assign raddr    = AW'(32'(i_idx) * MAX_BAD_BLOCKS + 32'(j_reg[JW-1:0]));

    bbmp_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (waddr),
        .wdata ({pos_reg, amt_reg}),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_start = rdata[2*POS_W-1:POS_W];
    assign rd_len   = rdata[POS_W-1:0];
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
    assign left     = POS_W'(rd_end - {1'b0, pos_reg});
    assign lim      = (cur_size < output_length_reg) ? cur_size : output_length_reg;
    assign lim_cnt  = (lim > pos_reg) ? lim - pos_reg : '0;

    always_comb
    begin
        stat.command   = cmd_reg;
        stat.img_ok    = img_ok;
        stat.list_full = fill_reg[img_idx] == FW'(MAX_BAD_BLOCKS);
        stat.i_end     = i_reg == n_eff;
        stat.j_end     = j_reg == cur_fill;
        stat.covers    = (pos_reg >= rd_start) && ({1'b0, pos_reg} < rd_end);
        stat.after     = rd_start > pos_reg;
        stat.at_pos    = rd_start == pos_reg;
        stat.better    = !found_reg || (left < best_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // config, fills and sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_count_reg   <= 4'd2;
            output_length_reg <= '0;
            for (int k = 0; k < MAX_IMAGES; k++)
            begin
                fill_reg[k] <= '0;
                size_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_IMAGE_COUNT)
                begin
                    image_count_reg <= cfg_data[3:0];
                end
                else
                begin
                    output_length_reg <= cfg_data;
                end
            end
            if (cmd.clear_lists)
            begin
                for (int k = 0; k < MAX_IMAGES; k++)
                begin
                    fill_reg[k] <= '0;
                end
            end
            if (cmd.append)
            begin
                fill_reg[img_idx] <= fill_reg[img_idx] + FW'(1);
            end
            if (cmd.set_size)
            begin
                size_reg[img_idx] <= amt_reg;
            end
        end
    end

    // latched word and scan state
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg <= command;
            img_reg <= image;
            pos_reg <= offset;
            amt_reg <= amount;
        end
        if (cmd.scan_reset)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            ge_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        if (cmd.next_entry)
        begin
            j_reg <= j_reg + FW'(1);
        end
        if (cmd.next_image)
        begin
            i_reg  <= i_reg + IW1'(1);
            j_reg  <= '0;
            ge_reg <= 1'b0;
        end
        if (cmd.mark_ge)
        begin
            ge_reg <= 1'b1;
        end
        if (cmd.vote_update)
        begin
            found_reg    <= 1'b1;
            best_reg     <= left;
            best_img_reg <= i_reg;
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_OK:
                begin
                    res_act_reg <= ACT_OK;
                    res_img_reg <= '0;
                    res_cnt_reg <= '0;
                end
                RES_COPY_LIM:
                begin
                    res_act_reg <= ACT_COPY;
                    res_img_reg <= 3'(i_reg);
                    res_cnt_reg <= ge_reg ? '0 : lim_cnt;
                end
                RES_COPY_GAP:
                begin
                    res_act_reg <= ACT_COPY;
                    res_img_reg <= 3'(i_reg);
                    res_cnt_reg <= ge_reg ? '0 : rd_start - pos_reg;
                end
                RES_VOTE:
                begin
                    res_act_reg <= found_reg ? ACT_VOTE : ACT_ERROR;
                    res_img_reg <= found_reg ? 3'(best_img_reg) : 3'd0;
                    res_cnt_reg <= found_reg ? best_reg : '0;
                end
                default:
                begin
                    res_act_reg <= ACT_ERROR;
                    res_img_reg <= '0;
                    res_cnt_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            action_reg       <= res_act_reg;
            source_image_reg <= res_img_reg;
            byte_count_reg   <= res_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign source_image = source_image_reg;
    assign byte_count   = byte_count_reg;
endmodule

/* hw/rtl/bad_block_merge_planner.sv */
// Top level of the bad-block merge planner: sequencer plus datapath.
// Depends on bbmp_pkg, bbmp_ctrl, bbmp_dp (and bbmp_ram below it).
//
// Channel   Direction  Handshake             Word
// -------   ---------  --------------------  ---------------------------------
// input     in         in_valid / in_ready   command, image, offset, amount
// result    out        out_valid / out_ready action, source_image, byte_count
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A query runs the copy scan and, when every image is bad at the offset,
// the vote scan. Each interval in a scan is read through the interval
// RAM's single read port and then evaluated (one read, one evaluate).
// Reset clears fills, sizes and config to their defaults; the interval
// store is not cleared. One word is in work at a time; the result register
// holds a finished word while the next input word is accepted, and a
// stalled result side only blocks the block once a second result is ready.
module bad_block_merge_planner #(
    parameter int MAX_IMAGES     = bbmp_pkg::DEF_MAX_IMAGES,
    parameter int MAX_BAD_BLOCKS = bbmp_pkg::DEF_MAX_BAD_BLOCKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [2:0]  image,
    input  logic [47:0] offset,
    input  logic [47:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [2:0]  source_image,
    output logic [47:0] byte_count
);
    import bbmp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // config writes must only arrive while idle; the block does not enforce it and always takes them
    assign cfg_ready = 1'b1;

    bbmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbmp_dp #(
        .MAX_IMAGES     (MAX_IMAGES),
        .MAX_BAD_BLOCKS (MAX_BAD_BLOCKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .image        (image),
        .offset       (offset),
        .amount       (amount),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .action       (action),
        .source_image (source_image),
        .byte_count   (byte_count),
        .cmd          (cmd),
        .stat         (stat)
    );
endmodule

/* test/bad_block_merge_planner_test.sv */
// Self-checking testbench for bad_block_merge_planner: directed and random command words,
// a built-in planner model that predicts every answer, with randomised stalls on both channels.
// Depends on bbmp_pkg and the RTL of bad_block_merge_planner only.
`timescale 1ns / 1ps

module bad_block_merge_planner_test;
    import bbmp_pkg::*;

    localparam int IMAGES  = DEF_MAX_IMAGES;
    localparam int ENTRIES = DEF_MAX_BAD_BLOCKS;
    localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

    // One input word as queued for the driver; 'hold' makes the driver wait until
    // every outstanding answer has come back before offering it.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  img;
        logic [47:0] pos;
        logic [47:0] amt;
        logic        hold;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [2:0]  src;
        logic [47:0] cnt;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [2:0]  image;
    logic [47:0] offset;
    logic [47:0] amount;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  action;
    logic [2:0]  source_image;
    logic [47:0] byte_count;

    bad_block_merge_planner DUT (.*);

    // Planner model state: interval lists, fills and sizes per image plus both registers.
    logic [47:0] m_start [IMAGES][ENTRIES];
    logic [47:0] m_len   [IMAGES][ENTRIES];
    int          m_fill  [IMAGES];
    logic [47:0] m_size  [IMAGES];
    logic [3:0]  m_count;
    logic [47:0] m_outlen;

    cmd_word_t pending_words[$];
    answer_t   expected_answers[$];
    int        fails;
    int        send_idle;
    int        recv_idle;
    logic      word_taken;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Works out the answer to one accepted word and updates the model state.
    function automatic answer_t plan_answer(cmd_word_t w);
        answer_t     a;
        int          n;
        int          bi;
        bit          clean;
        bit          found;
        bit          done;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] lim;
        logic [63:0] best;
        logic [63:0] left;
        a = '{act: ACT_OK, src: 3'd0, cnt: 48'd0};
        p = {16'd0, w.pos};
        case (w.cmd)
            CMD_CLEAR:
            begin
                for (int i = 0; i < IMAGES; i++)
                    m_fill[i] = 0;
            end
            CMD_APPEND:
            begin
                if (m_fill[w.img] >= ENTRIES)
                    a.act = ACT_ERROR;
                else
                begin
                    m_start[w.img][m_fill[w.img]] = w.pos;
                    m_len[w.img][m_fill[w.img]]   = w.amt;
                    m_fill[w.img]++;
                end
            end
            CMD_SIZE:
                m_size[w.img] = w.amt;
            default:
            begin
                n = (m_count > IMAGES) ? IMAGES : int'(m_count);
                // first image with no interval over the offset; scan stops at the
                // first covering entry or the first one starting past the offset
                for (int i = 0; i < n; i++)
                begin
                    clean = 1'b1;
                    for (int j = 0; j < m_fill[i]; j++)
                    begin
                        s = {16'd0, m_start[i][j]};
                        e = s + {16'd0, m_len[i][j]};
                        if (p >= s && p < e)
                        begin
                            clean = 1'b0;
                            break;
                        end
                        if (s > p)
                            break;
                    end
                    if (clean)
                    begin
                        a.act = ACT_COPY;
                        a.src = i[2:0];
                        done  = 1'b0;
                        for (int j = 0; j < m_fill[i]; j++)
                        begin
                            s = {16'd0, m_start[i][j]};
                            if (s >= p)
                            begin
                                a.cnt = 48'(s - p);
                                done  = 1'b1;
                                break;
                            end
                        end
                        if (!done)
                        begin
                            lim = (m_size[i] < m_outlen) ? {16'd0, m_size[i]}
                                                         : {16'd0, m_outlen};
                            a.cnt = (lim > p) ? 48'(lim - p) : 48'd0;
                        end
                        return a;
                    end
                end
                // every image bad here: nearest covering end wins, earlier image on a tie
                best  = 64'd1 << 62;
                found = 1'b0;
                bi    = 0;
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < m_fill[i]; j++)
                    begin
                        s = {16'd0, m_start[i][j]};
                        e = s + {16'd0, m_len[i][j]};
                        if (p >= s && p < e)
                        begin
                            left = e - p;
                            if (left < best)
                            begin
                                best  = left;
                                bi    = i;
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (!found)
                    a.act = ACT_ERROR;
                else
                begin
                    a.act = ACT_VOTE;
                    a.src = bi[2:0];
                    a.cnt = best[47:0];
                end
            end
        endcase
        return a;
    endfunction

    // Driver: offers queued words at the falling edge, honouring the sender idle rate.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (pending_words.size() > 0
                && !(pending_words[0].hold && expected_answers.size() > 0)
                && $urandom_range(99) >= send_idle)
            begin
                command  <= pending_words[0].cmd;
                image    <= pending_words[0].img;
                offset   <= pending_words[0].pos;
                amount   <= pending_words[0].amt;
                in_valid <= 1'b1;
                void'(pending_words.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Monitor: applies config and accepted words to the model, checks each answer word.
    always @(posedge clk)
    begin
        answer_t exp_a;
        word_taken <= in_valid && in_ready;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IMAGE_COUNT)
                m_count = cfg_data[3:0];
            else
                m_outlen = cfg_data;
        end
        if (in_valid && in_ready)
            expected_answers.push_back(plan_answer('{command, image, offset, amount, 1'b0}));
        if (out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("answer word with nothing expected: action %0d", action);
                fails++;
            end
            else
            begin
                exp_a = expected_answers.pop_front();
                if (action !== exp_a.act)
                begin
                    $error("action: expected %0d, got %0d", exp_a.act, action);
                    fails++;
                end
                if (source_image !== exp_a.src)
                begin
                    $error("source_image: expected %0d, got %0d", exp_a.src, source_image);
                    fails++;
                end
                if (byte_count !== exp_a.cnt)
                begin
                    $error("byte_count: expected %0d, got %0d", exp_a.cnt, byte_count);
                    fails++;
                end
            end
        end
    end

    task automatic push_word(input logic [1:0] c, input logic [2:0] i,
                             input logic [47:0] p, input logic [47:0] a,
                             input logic h = 1'b0);
        pending_words.push_back('{c, i, p, a, h});
    endtask

    // Waits until the block has drained, then a little longer.
    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Well-formed traffic: clear, mostly sorted interval lists per image, sizes, then
    // queries around the intervals. Returns the number of words queued.
    task automatic queue_plan(input logic [47:0] base, input int max_ent, input logic hold,
                              output int words);
        logic [47:0] p;
        logic [47:0] len;
        int          k;
        words = 1;
        push_word(CMD_CLEAR, 3'd0, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        for (int i = 0; i < IMAGES; i++)
        begin
            if ($urandom_range(3) == 0)
                continue;
            k = int'($urandom_range(0, max_ent));
            p = base;
            for (int j = 0; j < k; j++)
            begin
                p   = p + 48'($urandom_range(0, 40));
                len = 48'($urandom_range(0, 30));
                if ($urandom_range(19) == 0)
                    p = base + 48'($urandom_range(0, 400));  // out-of-order entry
                push_word(CMD_APPEND, i[2:0], p, len);
                p = p + len;
                words++;
            end
            if ($urandom_range(9) == 0)
                push_word(CMD_SIZE, i[2:0], 48'd0, 48'({$urandom, $urandom}));
            else
                push_word(CMD_SIZE, i[2:0], 48'd0, base + 48'($urandom_range(0, 600)));
            words++;
        end
        k = int'($urandom_range(3, 12));
        for (int q = 0; q < k; q++)
        begin
            push_word(CMD_QUERY, 3'($urandom), base + 48'($urandom_range(0, 700)),
                      48'({$urandom, $urandom}), hold && q == 0);
            words++;
        end
    endtask

    // One random phase: mostly well-formed plans, some raw noise words.
    task automatic run_phase(input int target, input logic [47:0] outlen_hint);
        int          sent;
        int          w;
        logic [47:0] base;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(9) < 7)
            begin
                case ($urandom_range(3))
                    0:       base = 48'd0;
                    1:       base = ALL_ONES - 48'd300;   // near the top, wraps
                    2:       base = 48'({$urandom, $urandom});
                    default: base = outlen_hint - 48'($urandom_range(0, 400));
                endcase
                queue_plan(base, 6, sent == 0, w);
                sent += w;
            end
            else
            begin
                w = int'($urandom_range(1, 4));
                for (int i = 0; i < w; i++)
                    push_word(2'($urandom), 3'($urandom), 48'({$urandom, $urandom}),
                              48'({$urandom, $urandom}));
                sent += w;
            end
            while (pending_words.size() > 40)
                @(posedge clk);
        end
    endtask

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [47:0] len_now;
        for (int i = 0; i < IMAGES; i++)
        begin
            m_fill[i] = 0;
            m_size[i] = '0;
        end
        m_count    = 4'd2;
        m_outlen   = '0;
        fails      = 0;
        send_idle  = 0;
        recv_idle  = 0;
        word_taken = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_IMAGE_COUNT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        command    = CMD_CLEAR;
        image      = '0;
        offset     = '0;
        amount     = '0;
        out_ready  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: three images, limit 1000.
        write_reg(CFG_IMAGE_COUNT, 48'd3);
        write_reg(CFG_OUTPUT_LENGTH, 48'd1000);
        push_word(CMD_QUERY, 3'd0, 48'd5, 48'd0);           // reset sizes are zero
        push_word(CMD_CLEAR, 3'd0, '0, '0);
        push_word(CMD_SIZE, 3'd0, '0, ALL_ONES);
        push_word(CMD_SIZE, 3'd1, '0, 48'd0);
        push_word(CMD_SIZE, 3'd2, '0, 48'd800);
        push_word(CMD_SIZE, 3'd7, ALL_ONES, 48'd77);
        push_word(CMD_APPEND, 3'd0, 48'd10, 48'd5);
        push_word(CMD_APPEND, 3'd0, 48'd20, 48'd0);         // zero-length interval
        push_word(CMD_APPEND, 3'd0, ALL_ONES - 48'd1, ALL_ONES);
        push_word(CMD_APPEND, 3'd1, 48'd8, 48'd10);
        push_word(CMD_APPEND, 3'd2, 48'd12, 48'd3);
        push_word(CMD_APPEND, 3'd7, 48'd0, 48'd1);
        push_word(CMD_QUERY, 3'd0, 48'd0, 48'd0);           // copy from image 0
        push_word(CMD_QUERY, 3'd0, 48'd10, 48'd0);          // falls to image 2
        push_word(CMD_QUERY, 3'd0, 48'd12, 48'd0);          // all bad, tie on end
        push_word(CMD_QUERY, 3'd0, 48'd20, 48'd0);          // zero-length next block
        push_word(CMD_QUERY, 3'd0, 48'd5000, 48'd0);        // past the limit
        push_word(CMD_QUERY, 3'd7, ALL_ONES, ALL_ONES);
        push_word(CMD_QUERY, 3'd0, 48'd30, 48'd0, 1'b1);
        wait_drained();

        // No image taking part: queries answer error.
        write_reg(CFG_IMAGE_COUNT, 48'd0);
        push_word(CMD_QUERY, 3'd0, 48'd12, 48'd0);
        push_word(CMD_QUERY, 3'd5, 48'd0, ALL_ONES);
        wait_drained();

        // Sender idles 25%, receiver 69%.
        send_idle = 25;
        recv_idle = 69;
        write_reg(CFG_IMAGE_COUNT, 48'd8);
        write_reg(CFG_OUTPUT_LENGTH, ALL_ONES);
        run_phase(90, ALL_ONES);
        wait_drained();
        write_reg(CFG_IMAGE_COUNT, 48'd15);                 // clamps to eight
        write_reg(CFG_OUTPUT_LENGTH, 48'd400);
        run_phase(40, 48'd400);
        wait_drained();

        // The other way round.
        send_idle = 69;
        recv_idle = 25;
        write_reg(CFG_IMAGE_COUNT, 48'd1);
        write_reg(CFG_OUTPUT_LENGTH, 48'd0);
        run_phase(70, 48'd600);
        wait_drained();
        len_now = 48'({$urandom, $urandom});
        write_reg(CFG_IMAGE_COUNT, 48'd5);
        write_reg(CFG_OUTPUT_LENGTH, len_now);
        run_phase(40, len_now);
        wait_drained();

        // No idling; a full list on image 5, then random traffic.
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_IMAGE_COUNT, 48'd6);
        write_reg(CFG_OUTPUT_LENGTH, 48'd100000);
        push_word(CMD_CLEAR, 3'd0, '0, '0);
        for (int j = 0; j <= ENTRIES; j++)
            push_word(CMD_APPEND, 3'd5, 48'(j * 8), 48'd4);
        push_word(CMD_QUERY, 3'd0, 48'd1, 48'd0);
        push_word(CMD_CLEAR, 3'd0, '0, '0);
        run_phase(40, 48'd100000);
        wait_drained();
        repeat (20) @(posedge clk);

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
